// ----- src/mbsc_pkg.sv -----
// Shared constants, types and helper functions of the message byte classifier.
`default_nettype none

package mbsc_pkg;

	localparam int COUNT_WIDTH_DEFAULT = 32;

	localparam logic [15:0] LINE_LIMIT_RESET = 16'd988;

	localparam logic [7:0] CHAR_NUL   = 8'd0;
	localparam logic [7:0] CHAR_TAB   = 8'd9;
	localparam logic [7:0] CHAR_LF    = 8'd10;
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_TILDE = 8'd126;
	localparam logic [7:0] CHAR_F     = 8'd70;

	// Length of the "From " marker.
	localparam logic [2:0] FROM_LEN = 3'd5;

	typedef enum logic [2:0] {
		CLASS_BINARY = 3'd0,
		CLASS_TEXT7  = 3'd1,
		CLASS_DATA7  = 3'd2,
		CLASS_TEXT8  = 3'd3,
		CLASS_DATA8  = 3'd4
	} content_class_t;

	typedef struct packed {
		logic trailing_space;
		logic leading_from;
	} mbsc_flags_t;

	// Expected byte of the "From " marker at a given match position.
	function automatic logic [7:0] from_char(input logic [2:0] pos);
		logic [7:0] ch;
		unique case (pos)
			3'd0: ch = 8'd70;   // F
			3'd1: ch = 8'd114;  // r
			3'd2: ch = 8'd111;  // o
			3'd3: ch = 8'd109;  // m
			default: ch = 8'd32;
		endcase
		return ch;
	endfunction

	function automatic logic is_blank(input logic [7:0] ch);
		return (ch == CHAR_TAB) || (ch == CHAR_SPACE);
	endfunction

endpackage

`default_nettype wire

// ----- src/mime_byte_stream_classifier.sv -----
// Top level of the message byte classifier: input register, scan, summary stage and result.
// A final byte passes the input register, the summary stage and the result register.
// Throughput: one byte per cycle, set by the scan state, which is updated for every byte.
// A byte that is not final gives no result; only a stalled result slows the input.
// Reset (arst_n low, asynchronous) clears all tallies and flags, empties the pipeline
// and loads line_limit with 988.
`default_nettype none

module mime_byte_stream_classifier
	import mbsc_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write of line_limit.
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	// Byte channel.
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_message,
	// Result channel.
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [2:0]       content_class,
	output logic             trailing_space,
	output logic             leading_from,
	output logic [31:0]      nul_count,
	output logic [31:0]      control_count,
	output logic [31:0]      lf_count,
	output logic [31:0]      crlf_count,
	output logic [31:0]      printable_count,
	output logic [31:0]      eight_bit_count,
	output logic [31:0]      byte_total,
	output logic [31:0]      shortest_line,
	output logic [31:0]      longest_line
);

	localparam int CW   = COUNT_WIDTH;
	// Width that holds both a tally and the 32-bit output limit.
	localparam int XW   = (CW > 32) ? CW : 32;
	// Width for comparing the longest line against the 16-bit limit.
	localparam int LW   = (CW > 16) ? CW : 16;

	// Clamp a tally to the 32-bit output field.
	function automatic logic [31:0] to32(input logic [CW-1:0] x);
		logic [XW-1:0] xw;
		xw = XW'(x);
		return (xw > XW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : xw[31:0];
	endfunction

	// The configuration register. The user must write it only while the block is idle; the block does not enforce this.
	logic [15:0] line_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_limit_q <= LINE_LIMIT_RESET;
		end else if (cfg_we) begin
			line_limit_q <= cfg_wdata;
		end
	end

	// Stage 1 is the input register. Each byte held there updates the scan
	// state when it leaves stage 1. A final byte also needs room in stage 2,
	// which holds the finished tallies of a message until the result register
	// can take them.
	logic       valid_s1, eom_s1;
	logic [7:0] data_s1;
	logic       valid_s2;
	logic       s1_fire, s2_load, out_take, byte_take;

	always_comb begin
		out_take   = valid_s2 && (!result_valid || !result_stall);
		s1_fire    = valid_s1 && (!eom_s1 || !valid_s2 || out_take);
		s2_load    = s1_fire && eom_s1;
		byte_stall = valid_s1 && !s1_fire;
		byte_take  = byte_valid && !byte_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_take) begin
			data_s1 <= data_byte;
			eom_s1  <= end_of_message;
		end
	end

	// Scan state with the values that hold after the byte in stage 1.
	logic [CW-1:0] nul_n, ctl_n, cr_n, lf_n, crlf_n, prt_n, eight_n, total_n;
	logic [CW-1:0] min_n, max_n;
	mbsc_flags_t   flags_n;

	mbsc_scan #(
		.COUNT_WIDTH(CW)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (s1_fire),
		.data_byte(data_s1),
		.last     (eom_s1),
		.nul      (nul_n),
		.ctl      (ctl_n),
		.cr       (cr_n),
		.lf       (lf_n),
		.crlf     (crlf_n),
		.prt      (prt_n),
		.eight    (eight_n),
		.total    (total_n),
		.min_len  (min_n),
		.max_len  (max_n),
		.flags    (flags_n)
	);

	// Stage 2: summary of a finished message.
	logic [CW-1:0] nul_s2, ctl_s2, cr_s2, lf_s2, crlf_s2, prt_s2, eight_s2, total_s2;
	logic [CW-1:0] min_s2, max_s2;
	mbsc_flags_t   flags_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= 1'b1;
		end else if (out_take) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			nul_s2   <= nul_n;
			ctl_s2   <= ctl_n;
			cr_s2    <= cr_n;
			lf_s2    <= lf_n;
			crlf_s2  <= crlf_n;
			prt_s2   <= prt_n;
			eight_s2 <= eight_n;
			total_s2 <= total_n;
			min_s2   <= min_n;
			max_s2   <= max_n;
			flags_s2 <= flags_n;
		end
	end

	// Classification. The control ratio test compares five times the control
	// tally with the total, which matches control > floor(total / 5) exactly.
	logic [CW+2:0]  ctl_x5;
	logic           is_data;
	content_class_t class_s2;

	always_comb begin
		ctl_x5  = ({3'b000, ctl_s2} << 2) + {3'b000, ctl_s2};
		is_data = (LW'(max_s2) > LW'(line_limit_q)) ||
		          ((lf_s2 != crlf_s2) && (crlf_s2 != '0)) ||
		          (cr_s2 != crlf_s2) ||
		          (ctl_x5 > {3'b000, total_s2});
		priority if (nul_s2 != '0) begin
			class_s2 = CLASS_BINARY;
		end else if (eight_s2 != '0) begin
			class_s2 = is_data ? CLASS_DATA8 : CLASS_TEXT8;
		end else begin
			class_s2 = is_data ? CLASS_DATA7 : CLASS_TEXT7;
		end
	end

	// Result register. It holds a result while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_take) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take) begin
			content_class   <= class_s2;
			trailing_space  <= flags_s2.trailing_space;
			leading_from    <= flags_s2.leading_from;
			nul_count       <= to32(nul_s2);
			control_count   <= to32(ctl_s2);
			lf_count        <= to32(lf_s2);
			crlf_count      <= to32(crlf_s2);
			printable_count <= to32(prt_s2);
			eight_bit_count <= to32(eight_s2);
			byte_total      <= to32(total_s2);
			shortest_line   <= to32(min_s2);
			longest_line    <= to32(max_s2);
		end
	end

`ifndef SYNTH
	// The byte channel only stalls behind a final byte waiting for stage 2.
	assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (valid_s1 && eom_s1 && valid_s2))
	else $error("byte channel stalled without a blocked final byte");

	// A summary in stage 2 is not lost while the result register is blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_valid && result_stall) |=> valid_s2)
	else $error("summary dropped while the result was stalled");

	// A new result only appears after a summary stood in stage 2.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(valid_s2))
	else $error("result appeared without a summary");
`endif

endmodule

`default_nettype wire

// ----- src/mbsc_scan.sv -----
// Per-message tallies, line length tracking and marker matching, one byte per cycle while fire is high.
`default_nettype none

module mbsc_scan
	import mbsc_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   fire,
	input  wire logic [7:0]             data_byte,
	input  wire logic                   last,
	output logic      [COUNT_WIDTH-1:0] nul,
	output logic      [COUNT_WIDTH-1:0] ctl,
	output logic      [COUNT_WIDTH-1:0] cr,
	output logic      [COUNT_WIDTH-1:0] lf,
	output logic      [COUNT_WIDTH-1:0] crlf,
	output logic      [COUNT_WIDTH-1:0] prt,
	output logic      [COUNT_WIDTH-1:0] eight,
	output logic      [COUNT_WIDTH-1:0] total,
	output logic      [COUNT_WIDTH-1:0] min_len,
	output logic      [COUNT_WIDTH-1:0] max_len,
	output mbsc_flags_t                 flags
);

	localparam int CW = COUNT_WIDTH;

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] x);
		return (&x) ? x : x + CW'(1);
	endfunction

	logic [CW-1:0] nul_q, ctl_q, cr_q, lf_q, crlf_q, prt_q, eight_q, total_q;
	logic [CW-1:0] len_q, min_q, max_q;
	logic [7:0]    prev_q, prev2_q;
	logic          space_q, from_q;
	logic [2:0]    fpos_q;

	logic          is_nul, is_cr, is_lf, is_prt, is_eight, is_ctl, prev_cr;
	logic [CW-1:0] len_inc, lf_line, fin_line, len_n;
	logic [CW-1:0] min_a, max_a, min_b, max_b;
	logic [CW-1:0] nul_n, ctl_n, cr_n, lf_n, crlf_n, prt_n, eight_n, total_n;
	logic          space_n, from_n;
	logic [2:0]    fpos_n;

	always_comb begin
		is_nul   = (data_byte == CHAR_NUL);
		is_cr    = (data_byte == CHAR_CR);
		is_lf    = (data_byte == CHAR_LF);
		is_prt   = (data_byte == CHAR_TAB) ||
		           ((data_byte >= CHAR_SPACE) && (data_byte <= CHAR_TILDE));
		is_eight = data_byte[7];
		is_ctl   = !is_nul && !is_cr && !is_lf && !is_prt && !is_eight;
		prev_cr  = (prev_q == CHAR_CR);

		// The incremented length is never zero, so one less is always safe.
		len_inc = sat_inc(len_q);
		if (prev_cr) begin
			lf_line = (len_inc >= CW'(2)) ? len_inc - CW'(2) : '0;
		end else begin
			lf_line = len_inc - CW'(1);
		end
		len_n = is_lf ? '0 : len_inc;

		min_a = (is_lf && (lf_line < min_q)) ? lf_line : min_q;
		max_a = (is_lf && (lf_line > max_q)) ? lf_line : max_q;

		// The final line of a message also counts, zero after a closing LF.
		fin_line = len_n;
		min_b = (fin_line < min_a) ? fin_line : min_a;
		max_b = (fin_line > max_a) ? fin_line : max_a;

		nul_n   = is_nul   ? sat_inc(nul_q)   : nul_q;
		cr_n    = is_cr    ? sat_inc(cr_q)    : cr_q;
		lf_n    = is_lf    ? sat_inc(lf_q)    : lf_q;
		crlf_n  = (is_lf && prev_cr) ? sat_inc(crlf_q) : crlf_q;
		prt_n   = is_prt   ? sat_inc(prt_q)   : prt_q;
		ctl_n   = is_ctl   ? sat_inc(ctl_q)   : ctl_q;
		eight_n = is_eight ? sat_inc(eight_q) : eight_q;
		total_n = sat_inc(total_q);

		space_n = space_q || (is_lf && (is_blank(prev_q) ||
		          (prev_cr && is_blank(prev2_q))));

		// The marker matcher only starts at the beginning of a line.
		from_n = from_q;
		fpos_n = 3'd0;
		if (fpos_q == 3'd0) begin
			if ((data_byte == CHAR_F) && (prev_q == CHAR_LF)) begin
				fpos_n = 3'd1;
			end
		end else if ((fpos_q < FROM_LEN) && (data_byte == from_char(fpos_q))) begin
			if (fpos_q + 3'd1 == FROM_LEN) begin
				from_n = 1'b1;
			end else begin
				fpos_n = fpos_q + 3'd1;
			end
		end
	end

	always_comb begin
		nul     = nul_n;
		ctl     = ctl_n;
		cr      = cr_n;
		lf      = lf_n;
		crlf    = crlf_n;
		prt     = prt_n;
		eight   = eight_n;
		total   = total_n;
		min_len = min_b;
		max_len = max_b;
		flags.trailing_space = space_n || is_blank(data_byte);
		flags.leading_from   = from_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nul_q   <= '0;
			ctl_q   <= '0;
			cr_q    <= '0;
			lf_q    <= '0;
			crlf_q  <= '0;
			prt_q   <= '0;
			eight_q <= '0;
			total_q <= '0;
			len_q   <= '0;
			min_q   <= '1;
			max_q   <= '0;
			prev_q  <= CHAR_LF;
			prev2_q <= CHAR_NUL;
			space_q <= 1'b0;
			from_q  <= 1'b0;
			fpos_q  <= 3'd0;
		end else if (fire) begin
			if (last) begin
				nul_q   <= '0;
				ctl_q   <= '0;
				cr_q    <= '0;
				lf_q    <= '0;
				crlf_q  <= '0;
				prt_q   <= '0;
				eight_q <= '0;
				total_q <= '0;
				len_q   <= '0;
				min_q   <= '1;
				max_q   <= '0;
				prev_q  <= CHAR_LF;
				prev2_q <= CHAR_NUL;
				space_q <= 1'b0;
				from_q  <= 1'b0;
				fpos_q  <= 3'd0;
			end else begin
				nul_q   <= nul_n;
				ctl_q   <= ctl_n;
				cr_q    <= cr_n;
				lf_q    <= lf_n;
				crlf_q  <= crlf_n;
				prt_q   <= prt_n;
				eight_q <= eight_n;
				total_q <= total_n;
				len_q   <= len_n;
				min_q   <= min_a;
				max_q   <= max_a;
				prev_q  <= data_byte;
				prev2_q <= prev_q;
				space_q <= space_n;
				from_q  <= from_n;
				fpos_q  <= fpos_n;
			end
		end
	end

endmodule

`default_nettype wire

// ----- bench/mime_byte_stream_classifier_tb.sv -----
// Self-checking testbench of the message byte classifier with predictor and handshake stress.
`default_nettype none

module mime_byte_stream_classifier_tb
	import mbsc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// The result of a final byte passes the input register, the summary stage and the
	// result register; a settle time is allowed before the block is treated as quiet.
	localparam int SETTLE_CYCLES = 6;
	// Length of the long receiver hold-off in the backpressure test.
	localparam int HOLD_CYCLES = 250;
	localparam logic [7:0] CHAR_DEL = 8'd127;
	// The five bytes of the mailbox separator, first byte in the top bits.
	localparam logic [39:0] FROM_MARK = "From ";

	typedef enum int {EOL_LF, EOL_CRLF, EOL_MIXED} eol_style_t;

	// One message summary as the block reports it.
	typedef struct {
		content_class_t cls;
		logic           blank_end;
		logic           from_line;
		logic [31:0]    nuls;
		logic [31:0]    controls;
		logic [31:0]    lfs;
		logic [31:0]    crlfs;
		logic [31:0]    printables;
		logic [31:0]    high_bytes;
		logic [31:0]    total;
		logic [31:0]    shortest;
		logic [31:0]    longest;
	} summary_t;

	// Every input starts at a known value; later changes are made at rising edges.
	logic        clk;
	logic        arst_n         = 1'b0;
	logic        cfg_we         = 1'b0;
	logic [15:0] cfg_wdata      = '0;
	logic        byte_valid     = 1'b0;
	logic        byte_stall;
	logic [7:0]  data_byte      = '0;
	logic        end_of_message = 1'b0;
	logic        result_valid;
	logic        result_stall   = 1'b0;
	logic [2:0]  content_class;
	logic        trailing_space;
	logic        leading_from;
	logic [31:0] nul_count;
	logic [31:0] control_count;
	logic [31:0] lf_count;
	logic [31:0] crlf_count;
	logic [31:0] printable_count;
	logic [31:0] eight_bit_count;
	logic [31:0] byte_total;
	logic [31:0] shortest_line;
	logic [31:0] longest_line;

	mime_byte_stream_classifier dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.byte_valid      (byte_valid),
		.byte_stall      (byte_stall),
		.data_byte       (data_byte),
		.end_of_message  (end_of_message),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.content_class   (content_class),
		.trailing_space  (trailing_space),
		.leading_from    (leading_from),
		.nul_count       (nul_count),
		.control_count   (control_count),
		.lf_count        (lf_count),
		.crlf_count      (crlf_count),
		.printable_count (printable_count),
		.eight_bit_count (eight_bit_count),
		.byte_total      (byte_total),
		.shortest_line   (shortest_line),
		.longest_line    (longest_line)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Scan state of the predictor. It mirrors what the block keeps for the
	// message in progress, plus its own copy of the line limit register.
	logic [15:0] limit_model;
	logic [31:0] nul_n, ctl_n, cr_n, lf_n, crlf_n, prt_n, high_n, total_n;
	logic [31:0] line_len, min_len, max_len;
	logic [7:0]  prev_b, prev2_b;
	logic        blank_seen, from_seen;
	int unsigned from_pos;

	// Summaries still owed by the block, oldest first.
	summary_t    summary_q[$];
	// Bytes of the message being built by a test.
	logic [7:0]  msg_bytes[$];

	// Knobs shared by the test tasks, the byte-sending task and the result-side process.
	int unsigned tx_idle_pct  = 0;
	int unsigned rx_idle_pct  = 0;
	int unsigned hold_requests = 0;
	int unsigned holds_served  = 0;
	int unsigned hold_left     = 0;
	int unsigned mismatches    = 0;

	function automatic logic [31:0] bump(input logic [31:0] x);
		return (x == '1) ? x : x + 32'd1;
	endfunction

	function automatic logic is_white(input logic [7:0] ch);
		return (ch == CHAR_TAB) || (ch == CHAR_SPACE);
	endfunction

	function automatic logic [7:0] mark_char(input int unsigned pos);
		return FROM_MARK[39 - 8 * pos -: 8];
	endfunction

	// Start-of-message state. The line limit is not part of it.
	task automatic clear_scan();
		nul_n      = '0;
		ctl_n      = '0;
		cr_n       = '0;
		lf_n       = '0;
		crlf_n     = '0;
		prt_n      = '0;
		high_n     = '0;
		total_n    = '0;
		line_len   = '0;
		min_len    = '1;
		max_len    = '0;
		prev_b     = CHAR_LF;
		prev2_b    = CHAR_NUL;
		blank_seen = 1'b0;
		from_seen  = 1'b0;
		from_pos   = 0;
	endtask

	task automatic note_line(input logic [31:0] len);
		if (len > max_len)
			max_len = len;
		if (len < min_len)
			min_len = len;
	endtask

	// Advances the predictor by one accepted byte. On the final byte of a
	// message the expected summary is queued and the scan state starts over.
	task automatic scan_byte(input logic [7:0] b, input logic last);
		summary_t s;
		logic     data_like;
		line_len = bump(line_len);
		total_n  = bump(total_n);

		// The separator only counts at the start of a line. A wrong byte drops the
		// match, and does not start a new one even if it is an F.
		if (from_pos == 0) begin
			if (b == CHAR_F && prev_b == CHAR_LF)
				from_pos = 1;
		end else if (from_pos < 5 && b == mark_char(from_pos)) begin
			from_pos++;
			if (from_pos == 5) begin
				from_seen = 1'b1;
				from_pos  = 0;
			end
		end else begin
			from_pos = 0;
		end

		if (b == CHAR_NUL) begin
			nul_n = bump(nul_n);
		end else if (b == CHAR_CR) begin
			cr_n = bump(cr_n);
		end else if (b == CHAR_LF) begin
			lf_n = bump(lf_n);
			// The running length includes this LF, and the CR too after a CR;
			// both are taken off before the line is recorded.
			if (prev_b == CHAR_CR) begin
				if (line_len != 0)
					line_len--;
				crlf_n = bump(crlf_n);
			end
			note_line((line_len != 0) ? line_len - 32'd1 : 32'd0);
			if (is_white(prev_b) || (prev_b == CHAR_CR && is_white(prev2_b)))
				blank_seen = 1'b1;
			line_len = '0;
		end else if (b == CHAR_TAB || (b >= CHAR_SPACE && b <= CHAR_TILDE)) begin
			prt_n = bump(prt_n);
		end else if (b == CHAR_DEL || b < CHAR_SPACE) begin
			ctl_n = bump(ctl_n);
		end else begin
			high_n = bump(high_n);
		end

		prev2_b = prev_b;
		prev_b  = b;

		if (last) begin
			// The unterminated last line counts too; after a closing LF it is empty.
			note_line(line_len);
			if (is_white(b))
				blank_seen = 1'b1;
			data_like = (max_len > {16'd0, limit_model}) ||
				(lf_n != crlf_n && crlf_n != 0) ||
				(cr_n != crlf_n) ||
				(ctl_n > total_n / 32'd5);
			if (nul_n != 0)
				s.cls = CLASS_BINARY;
			else if (high_n != 0)
				s.cls = data_like ? CLASS_DATA8 : CLASS_TEXT8;
			else
				s.cls = data_like ? CLASS_DATA7 : CLASS_TEXT7;
			s.blank_end  = blank_seen;
			s.from_line  = from_seen;
			s.nuls       = nul_n;
			s.controls   = ctl_n;
			s.lfs        = lf_n;
			s.crlfs      = crlf_n;
			s.printables = prt_n;
			s.high_bytes = high_n;
			s.total      = total_n;
			s.shortest   = min_len;
			s.longest    = max_len;
			summary_q.push_back(s);
			clear_scan();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_summary();
		summary_t want;
		if (summary_q.size() == 0) begin
			$error("summary transaction with no message outstanding");
			mismatches++;
		end else begin
			want = summary_q.pop_front();
			check_field("content_class", want.cls, content_class);
			check_field("trailing_space", want.blank_end, trailing_space);
			check_field("leading_from", want.from_line, leading_from);
			check_field("nul_count", want.nuls, nul_count);
			check_field("control_count", want.controls, control_count);
			check_field("lf_count", want.lfs, lf_count);
			check_field("crlf_count", want.crlfs, crlf_count);
			check_field("printable_count", want.printables, printable_count);
			check_field("eight_bit_count", want.high_bytes, eight_bit_count);
			check_field("byte_total", want.total, byte_total);
			check_field("shortest_line", want.shortest, shortest_line);
			check_field("longest_line", want.longest, longest_line);
		end
	endtask

	// Result side: every accepted summary is checked against the oldest
	// expectation, and the stall for the next edge is chosen here. A pending
	// hold-off request turns into a run of stalled cycles counted locally.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			check_summary();
		if (holds_served != hold_requests) begin
			holds_served++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	// Offers one byte, with random idle cycles first, and waits for the edge
	// that takes it. Valid stays high afterwards so back-to-back bytes flow.
	task automatic send_byte(input logic [7:0] value, input logic last);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid     <= 1'b1;
		data_byte      <= value;
		end_of_message <= last;
		do
			@(posedge clk);
		while (byte_stall);
		scan_byte(value, last);
	endtask

	task automatic send_message();
		for (int i = 0; i < msg_bytes.size(); i++)
			send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
	endtask

	task automatic queue_string(input string s);
		for (int i = 0; i < s.len(); i++)
			msg_bytes.push_back(s[i]);
	endtask

	// Stops offering bytes and waits until every summary has come back, then
	// lets the pipeline settle.
	task automatic drain_results();
		byte_valid <= 1'b0;
		while (summary_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The register is only written with the block quiet.
	task automatic write_limit(input logic [15:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we      <= 1'b0;
		limit_model = value;
	endtask

	function automatic logic [7:0] text_byte(input int unsigned ctl_pct, input logic high_ok);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < ctl_pct)
			return ($urandom_range(0, 3) == 0) ? CHAR_DEL : 8'($urandom_range(1, 31));
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return CHAR_TAB;
		if (high_ok && roll < 20)
			return 8'($urandom_range(128, 255));
		return 8'($urandom_range(32, 126));
	endfunction

	task automatic push_line_end(input eol_style_t style);
		case (style)
			EOL_LF: begin
				msg_bytes.push_back(CHAR_LF);
			end
			EOL_CRLF: begin
				msg_bytes.push_back(CHAR_CR);
				msg_bytes.push_back(CHAR_LF);
			end
			default: begin
				case ($urandom_range(0, 3))
					0: msg_bytes.push_back(CHAR_LF);
					1: msg_bytes.push_back(CHAR_CR);
					default: begin
						msg_bytes.push_back(CHAR_CR);
						msg_bytes.push_back(CHAR_LF);
					end
				endcase
			end
		endcase
	endtask

	// Builds one random message. Most are line-structured text with random
	// content: separator lines, broken separators, blanks before line ends,
	// a few long lines; some of these messages are control-heavy. The rest are raw noise.
	task automatic fill_message();
		int unsigned style, lines, body, ctl_pct;
		logic        high_ok;
		eol_style_t  eol;
		msg_bytes.delete();
		style   = $urandom_range(0, 9);
		high_ok = ($urandom_range(0, 2) == 0);
		ctl_pct = (style == 1) ? 25 : 2;
		eol     = eol_style_t'($urandom_range(0, 2));
		if (style == 0) begin
			body = $urandom_range(1, 24);
			repeat (body) msg_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			lines = $urandom_range(1, 4);
			for (int k = 0; k < lines; k++) begin
				if ($urandom_range(0, 3) == 0) begin
					case ($urandom_range(0, 5))
						4: queue_string("Fro");
						5: queue_string("FFrom ");
						default: queue_string("From ");
					endcase
				end
				body = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 70)
					: $urandom_range(0, 10);
				repeat (body) msg_bytes.push_back(text_byte(ctl_pct, high_ok));
				if ($urandom_range(0, 4) == 0)
					msg_bytes.push_back(($urandom_range(0, 1) == 0) ? CHAR_TAB : CHAR_SPACE);
				if (k < lines - 1 || $urandom_range(0, 1) == 0)
					push_line_end(eol);
			end
			if (msg_bytes.size() == 0)
				msg_bytes.push_back(text_byte(ctl_pct, high_ok));
		end
	endtask

	// Hand-picked messages: byte extremes, one of each counting class, the
	// separator found and missed, blanks before CRLF, before LF and at the end,
	// and a lone CR that makes the message data.
	task automatic test_directed();
		msg_bytes = '{CHAR_NUL};
		send_message();
		msg_bytes = '{8'hFF};
		send_message();
		msg_bytes.delete();
		queue_string("From a ");
		msg_bytes.push_back(CHAR_CR);
		msg_bytes.push_back(CHAR_LF);
		send_message();
		msg_bytes = '{CHAR_DEL, 8'h80, 8'h01, CHAR_LF, 8'h78, CHAR_CR, CHAR_SPACE};
		send_message();
		msg_bytes = '{CHAR_F, 8'h72, CHAR_F, CHAR_TAB, CHAR_LF};
		send_message();
	endtask

	// Runs messages under several line limits, both extremes included.
	task automatic test_line_limit();
		logic [15:0] limits[5];
		limits = '{16'd0, 16'd1, 16'd7, 16'hFFFF, 16'($urandom_range(0, 65535))};
		foreach (limits[i]) begin
			write_limit(limits[i]);
			repeat (5) begin
				fill_message();
				send_message();
			end
		end
	endtask

	// Random messages with the given idle rates until the byte budget is used.
	task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
		input logic [15:0] limit, input int unsigned budget);
		int unsigned sent;
		write_limit(limit);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		sent = 0;
		while (sent < budget) begin
			fill_message();
			send_message();
			sent += msg_bytes.size();
		end
	endtask

	// The receiver holds off for a long stretch while short messages keep
	// coming, so the block fills and stalls the byte channel; then the sender
	// waits for every summary before anything else happens.
	task automatic test_backpressure();
		drain_results();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_requests++;
		repeat (30) begin
			msg_bytes.delete();
			repeat ($urandom_range(1, 3)) msg_bytes.push_back(text_byte(10, 1'b1));
			send_message();
		end
		drain_results();
	endtask

	initial begin
		limit_model = LINE_LIMIT_RESET;
		clear_scan();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_line_limit();
		test_random_traffic(11, 59, 16'd12, 240);
		test_random_traffic(59, 11, 16'd40, 240);
		test_random_traffic(0, 0, LINE_LIMIT_RESET, 240);
		test_backpressure();

		// Anything still owed or arriving late shows up as a failure here.
		drain_results();
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog: a run that hangs is ended as a failure.
	initial begin
		#3ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
